// ----- design/avccps_pkg.sv -----
package avccps_pkg;

  // Parser phases of the configuration record
  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_SPS_COUNT = 3'd1,
    PH_SPS_LEN   = 3'd2,
    PH_SPS_DATA  = 3'd3,
    PH_PPS_COUNT = 3'd4,
    PH_PPS_LEN   = 3'd5,
    PH_PPS_DATA  = 3'd6,
    PH_TAIL      = 3'd7
  } phase_e;

  // Completion status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_NO_SPS    = 2'd2;

  // Index of the final fixed header byte
  localparam logic [2:0]  HEADER_LAST    = 3'd4;
  // Low five bits of the SPS count byte hold the count
  localparam logic [7:0]  SPS_COUNT_MASK = 8'h1f;
  localparam logic [15:0] TOTAL_MAX      = 16'hffff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        is_pps;
    logic        unit_start;
    logic        unit_end;
    logic [7:0]  unit_number;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] sps_total;
    logic [15:0] pps_total;
  } out_item_t;

endpackage

// ----- design/avcc_parameter_set_splitter.sv -----
// Splits the SPS and PPS payloads out of an H.264 decoder configuration record.
// Input channel: one record byte per transaction (in_valid_i / in_stall_o), with
// last_byte set on the final byte of the record. Output channel: exactly one
// result per input byte (out_valid_o / out_stall_i), tagging payload bytes with
// kind, unit index and start/end marks, and carrying saturating SPS/PPS totals.
// The result for the last byte has done_res set and a status: ok, truncated, or
// no SPS present. After that byte the parser returns to its reset state, so
// the next byte starts a new record.
// A byte accepted on in_valid_i enters the input register; once the result
// register is free, the parser writes its result there, shown on out_valid_o.
// Throughput: one byte per cycle while out_stall_i is low; the parser state is
// a set of small counters updated in the single pass between the input and
// result registers. When the receiver stalls, the result register holds; the
// input register still takes one more byte if it is empty, after which
// in_stall_o follows out_stall_i.
// Reset (rst_ni low, asynchronous) empties both registers and clears the
// parser state and totals.
module avcc_parameter_set_splitter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  avccps_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output avccps_pkg::out_item_t out_data_o
);
  import avccps_pkg::*;

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res;

  logic      out_ready;
  logic      parse_fire;

  phase_e      phase_q, phase_d;
  logic [2:0]  hpos_q, hpos_d;
  logic [7:0]  sets_q, sets_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] sps_tot_q, sps_tot_d;
  logic [15:0] pps_tot_q, pps_tot_d;

  logic        is_pps_ph;
  logic [7:0]  sets_dec;
  logic [7:0]  b;

  // Handshake: result register frees when empty or taken
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign parse_fire = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  assign b        = in_q.data_byte;
  assign sets_dec = (sets_q != 8'd0) ? sets_q - 8'd1 : 8'd0;

  // Parse one byte: next state and result
  always_comb begin
    phase_d   = phase_q;
    hpos_d    = hpos_q;
    sets_d    = sets_q;
    len_hi_d  = len_hi_q;
    left_d    = left_q;
    cnt_d     = cnt_q;
    sps_tot_d = sps_tot_q;
    pps_tot_d = pps_tot_q;
    is_pps_ph = 1'b0;
    res       = '0;

    unique case (phase_q)
      PH_HEADER: begin
        if (hpos_q >= HEADER_LAST) begin
          phase_d = PH_SPS_COUNT;
          hpos_d  = 3'd0;
        end else begin
          hpos_d = hpos_q + 3'd1;
        end
      end
      PH_SPS_COUNT, PH_PPS_COUNT: begin
        is_pps_ph = (phase_q == PH_PPS_COUNT);
        sets_d    = is_pps_ph ? b : (b & SPS_COUNT_MASK);
        cnt_d     = 8'd0;
        hpos_d    = 3'd0;
        if (sets_d == 8'd0) begin
          phase_d = is_pps_ph ? PH_TAIL : PH_PPS_COUNT;
        end else begin
          phase_d = is_pps_ph ? PH_PPS_LEN : PH_SPS_LEN;
        end
      end
      PH_SPS_LEN, PH_PPS_LEN: begin
        is_pps_ph = (phase_q == PH_PPS_LEN);
        if (hpos_q == 3'd0) begin
          len_hi_d = b;
          hpos_d   = 3'd1;
        end else begin
          left_d = {len_hi_q, b};
          hpos_d = 3'd0;
          if (left_d == 16'd0) begin
            // Empty unit: consume its index and move on
            sets_d = sets_dec;
            cnt_d  = cnt_q + 8'd1;
            if (sets_dec == 8'd0) begin
              phase_d = is_pps_ph ? PH_TAIL : PH_PPS_COUNT;
            end else begin
              phase_d = is_pps_ph ? PH_PPS_LEN : PH_SPS_LEN;
            end
          end else begin
            phase_d = is_pps_ph ? PH_PPS_DATA : PH_SPS_DATA;
          end
        end
      end
      PH_SPS_DATA, PH_PPS_DATA: begin
        is_pps_ph         = (phase_q == PH_PPS_DATA);
        res.payload_valid = 1'b1;
        res.payload_byte  = b;
        res.is_pps        = is_pps_ph;
        res.unit_start    = (hpos_q == 3'd0);
        res.unit_end      = (left_q <= 16'd1);
        res.unit_number   = cnt_q;
        hpos_d            = 3'd1;
        if (is_pps_ph) begin
          if (pps_tot_q != TOTAL_MAX) pps_tot_d = pps_tot_q + 16'd1;
        end else begin
          if (sps_tot_q != TOTAL_MAX) sps_tot_d = sps_tot_q + 16'd1;
        end
        left_d = (left_q != 16'd0) ? left_q - 16'd1 : 16'd0;
        if (left_d == 16'd0) begin
          sets_d = sets_dec;
          cnt_d  = cnt_q + 8'd1;
          hpos_d = 3'd0;
          if (sets_dec == 8'd0) begin
            phase_d = is_pps_ph ? PH_TAIL : PH_PPS_COUNT;
          end else begin
            phase_d = is_pps_ph ? PH_PPS_LEN : PH_SPS_LEN;
          end
        end
      end
      PH_TAIL: begin
        // Ignore extension bytes until the record ends
      end
      default: begin
      end
    endcase

    res.done_res  = in_q.last_byte;
    res.sps_total = sps_tot_d;
    res.pps_total = pps_tot_d;
    if (in_q.last_byte) begin
      priority if (phase_d != PH_TAIL) begin
        res.status = ST_TRUNCATED;
      end else if (sps_tot_d == 16'd0) begin
        res.status = ST_NO_SPS;
      end else begin
        res.status = ST_OK;
      end
      // Return to reset for the next record
      phase_d   = PH_HEADER;
      hpos_d    = 3'd0;
      sets_d    = 8'd0;
      len_hi_d  = 8'd0;
      left_d    = 16'd0;
      cnt_d     = 8'd0;
      sps_tot_d = 16'd0;
      pps_tot_d = 16'd0;
    end
  end

  // Input register valid and result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (out_ready) out_valid_q <= in_valid_q;
    end
  end

  // Payload registers: capture on acceptance, hold when stalled
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_data_i;
    if (parse_fire) out_q <= res;
  end

  // Parser state: advance once per parsed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hpos_q    <= 3'd0;
      sets_q    <= 8'd0;
      len_hi_q  <= 8'd0;
      left_q    <= 16'd0;
      cnt_q     <= 8'd0;
      sps_tot_q <= 16'd0;
      pps_tot_q <= 16'd0;
    end else if (parse_fire) begin
      phase_q   <= phase_d;
      hpos_q    <= hpos_d;
      sets_q    <= sets_d;
      len_hi_q  <= len_hi_d;
      left_q    <= left_d;
      cnt_q     <= cnt_d;
      sps_tot_q <= sps_tot_d;
      pps_tot_q <= pps_tot_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // A nonzero status appears only on the closing result of a record
  a_status_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |-> out_data_o.done_res)
    else $error("status set on a result that is not the last of a record");

  // Non-payload results carry no unit tags
  a_tags_payload_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.payload_valid) |->
      (!out_data_o.is_pps && !out_data_o.unit_start && !out_data_o.unit_end &&
       out_data_o.unit_number == 8'd0))
    else $error("unit tags set on a non-payload result");

  // The last byte of a record returns the parser to its reset state
  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (parse_fire && in_q.last_byte) |=>
      (phase_q == PH_HEADER && hpos_q == 3'd0 && sps_tot_q == 16'd0 &&
       pps_tot_q == 16'd0))
    else $error("parser state not cleared after the last byte");
`endif

endmodule

// ----- verif/avccps_checker.sv -----
module avccps_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  avccps_pkg::in_item_t  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  avccps_pkg::out_item_t out_data_i,
  output int                    outstanding_o,
  output int                    fail_count_o
);
  import avccps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the record parser state
  phase_e      phase;
  logic [2:0]  hdr_pos;
  logic [7:0]  sets_left;
  logic [7:0]  len_high;
  logic [15:0] bytes_left;
  logic [7:0]  set_index;
  logic [15:0] sps_bytes;
  logic [15:0] pps_bytes;

  out_item_t expected_results[$];
  int        fails = 0;
  int        pending = 0;
  int        results_seen = 0;

  assign outstanding_o = pending;
  assign fail_count_o  = fails;

  function automatic void clear_parser();
    phase      = PH_HEADER;
    hdr_pos    = '0;
    sets_left  = '0;
    len_high   = '0;
    bytes_left = '0;
    set_index  = '0;
    sps_bytes  = '0;
    pps_bytes  = '0;
  endfunction

  // Step past a finished unit: next length field or next section
  function automatic void finish_unit(logic pps);
    if (sets_left != 0) sets_left = sets_left - 8'd1;
    set_index = set_index + 8'd1;
    hdr_pos   = '0;
    if (sets_left == 0) phase = pps ? PH_TAIL : PH_PPS_COUNT;
    else phase = pps ? PH_PPS_LEN : PH_SPS_LEN;
  endfunction

  // Advance the parser by one record byte and build the tagged result
  function automatic out_item_t parse_record_byte(in_item_t item);
    out_item_t res;
    logic      pps;
    res = '0;
    case (phase)
      PH_HEADER: begin
        if (hdr_pos >= HEADER_LAST) begin
          phase   = PH_SPS_COUNT;
          hdr_pos = '0;
        end else begin
          hdr_pos = hdr_pos + 3'd1;
        end
      end
      PH_SPS_COUNT, PH_PPS_COUNT: begin
        pps       = (phase == PH_PPS_COUNT);
        sets_left = pps ? item.data_byte : (item.data_byte & SPS_COUNT_MASK);
        set_index = '0;
        hdr_pos   = '0;
        if (sets_left == 0) phase = pps ? PH_TAIL : PH_PPS_COUNT;
        else phase = pps ? PH_PPS_LEN : PH_SPS_LEN;
      end
      PH_SPS_LEN, PH_PPS_LEN: begin
        pps = (phase == PH_PPS_LEN);
        if (hdr_pos == 0) begin
          len_high = item.data_byte;
          hdr_pos  = 3'd1;
        end else begin
          bytes_left = {len_high, item.data_byte};
          hdr_pos    = '0;
          if (bytes_left == 0) finish_unit(pps);
          else phase = pps ? PH_PPS_DATA : PH_SPS_DATA;
        end
      end
      PH_SPS_DATA, PH_PPS_DATA: begin
        pps               = (phase == PH_PPS_DATA);
        res.payload_valid = 1'b1;
        res.payload_byte  = item.data_byte;
        res.is_pps        = pps;
        res.unit_start    = (hdr_pos == 0);
        res.unit_end      = (bytes_left <= 16'd1);
        res.unit_number   = set_index;
        hdr_pos           = 3'd1;
        if (pps) begin
          if (pps_bytes != TOTAL_MAX) pps_bytes = pps_bytes + 16'd1;
        end else begin
          if (sps_bytes != TOTAL_MAX) sps_bytes = sps_bytes + 16'd1;
        end
        if (bytes_left != 0) bytes_left = bytes_left - 16'd1;
        if (bytes_left == 0) finish_unit(pps);
      end
      default: ;
    endcase

    // Report completion status on the final byte
    if (item.last_byte) begin
      if (phase != PH_TAIL) res.status = ST_TRUNCATED;
      else if (sps_bytes == 0) res.status = ST_NO_SPS;
      else res.status = ST_OK;
    end
    res.done_res  = item.last_byte;
    res.sps_total = sps_bytes;
    res.pps_total = pps_bytes;
    if (item.last_byte) clear_parser();
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (fails < 10)
        $display("result %0d field %s: expected 0x%0h, got 0x%0h",
                 results_seen, name, want, got);
      fails++;
    end
  endfunction

  // Match each result transaction against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      clear_parser();
      expected_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          if (fails < 10) $display("result %0d arrived with nothing expected", results_seen);
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("payload_valid", want.payload_valid, out_data_i.payload_valid);
          check_field("payload_byte", want.payload_byte, out_data_i.payload_byte);
          check_field("is_pps", want.is_pps, out_data_i.is_pps);
          check_field("unit_start", want.unit_start, out_data_i.unit_start);
          check_field("unit_end", want.unit_end, out_data_i.unit_end);
          check_field("unit_number", want.unit_number, out_data_i.unit_number);
          check_field("done_res", want.done_res, out_data_i.done_res);
          check_field("status", want.status, out_data_i.status);
          check_field("sps_total", want.sps_total, out_data_i.sps_total);
          check_field("pps_total", want.pps_total, out_data_i.pps_total);
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(parse_record_byte(in_data_i));
    end
    pending = expected_results.size();
  end

endmodule

// ----- verif/testbench.sv -----
module testbench;
  import avccps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1280;
  localparam int CYCLE_LIMIT  = 1000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        outstanding;
  int        fail_count;

  logic [7:0] record_bytes[$];
  logic       calm = 1'b0;
  int         bytes_sent = 0;
  int         cycles = 0;

  avcc_parameter_set_splitter u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_item)
  );

  avccps_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_item),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_item),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  always #2 clk = ~clk;

  // Stall the result channel at random unless in a calm stretch
  always @(negedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 38);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one record byte and hold it until the transaction completes
  task automatic send_byte(input logic [7:0] value, input logic last);
    if (!calm) begin
      while ($urandom_range(0, 99) < 38) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= '{data_byte: value, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Send the built record, cut short after cut bytes when cut is set
  task automatic send_record(input int cut);
    int n;
    n = record_bytes.size();
    if (cut > 0 && cut < n) n = cut;
    for (int i = 0; i < n; i++) send_byte(record_bytes[i], i == n - 1);
    record_bytes.delete();
  endtask

  task automatic add_random(input int count);
    repeat (count) record_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Append a length field and its payload
  task automatic add_unit(input int len);
    logic [15:0] len16;
    len16 = 16'(len);
    record_bytes.push_back(len16[15:8]);
    record_bytes.push_back(len16[7:0]);
    add_random(len);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 256 + $urandom_range(0, 20);
    if (r < 82) return $urandom_range(0, 8);
    return $urandom_range(0, 40);
  endfunction

  // Build a well-formed record with random structure and content
  task automatic build_record();
    int n_sps;
    int n_pps;
    n_sps = ($urandom_range(0, 99) < 5) ? $urandom_range(4, 31) : $urandom_range(0, 3);
    n_pps = ($urandom_range(0, 99) < 5) ? $urandom_range(4, 20) : $urandom_range(0, 3);
    add_random(5);
    record_bytes.push_back({3'($urandom_range(0, 7)), 5'(n_sps)});
    repeat (n_sps) add_unit(pick_len());
    record_bytes.push_back(8'(n_pps));
    repeat (n_pps) add_unit(pick_len());
    add_random($urandom_range(0, 3));
  endtask

  initial begin
    int start;
    int roll;
    logic paused;
    paused = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Ordinary record with trailing extension bytes and spare count bits
    add_random(5);
    record_bytes.push_back(8'he1);
    add_unit(3);
    record_bytes.push_back(8'h01);
    add_unit(2);
    add_random(2);
    send_record(0);
    // Both counts zero: no SPS
    add_random(5);
    record_bytes.push_back(8'h00);
    record_bytes.push_back(8'h00);
    send_record(0);
    // Empty SPS unit still uses an index; one-byte PPS
    add_random(5);
    record_bytes.push_back(8'h01);
    add_unit(0);
    record_bytes.push_back(8'h01);
    add_unit(1);
    send_record(0);
    // Last byte inside the header
    add_random(5);
    send_record(1);
    // Last byte inside an SPS payload
    add_random(5);
    record_bytes.push_back(8'h01);
    add_unit(4);
    record_bytes.push_back(8'h00);
    send_record(9);

    // Hold off until every result is back
    wait_drained();

    // Full PPS count, mostly empty units, so the unit index runs high
    add_random(5);
    record_bytes.push_back(8'h01);
    add_unit(1);
    record_bytes.push_back(8'hff);
    repeat (254) add_unit(0);
    add_unit(1);
    send_record(0);

    // Random records: mostly well-formed, some cut short, some noise
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      calm = (bytes_sent - start > 700) && (bytes_sent - start < 1000);
      if (!paused && bytes_sent - start > 1200) begin
        paused = 1'b1;
        wait_drained();
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        add_random($urandom_range(1, 40));
        send_record(0);
      end else begin
        build_record();
        if (roll < 25) send_record($urandom_range(1, record_bytes.size() - 1));
        else send_record(0);
      end
    end
    calm = 1'b0;

    // Drain and let the pipeline settle
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/avccps_pkg.sv
design/avcc_parameter_set_splitter.sv
verif/avccps_checker.sv
verif/testbench.sv
